[sv/tam_pkg.sv]
// shared types, constants and state encodings for the thruster allocation mixer
package tam_pkg;

  localparam int AXIS_COUNT         = 6;
  localparam int THRUSTER_COUNT_DEF = 8;
  localparam int COEF_WIDTH_DEF     = 32;

  localparam int CMD_W       = 16;
  localparam int LIMIT_W     = 24;
  localparam int WORD_W      = 32;
  localparam int INDEX_W     = 6;
  localparam int DUTY_W      = 16;
  localparam int TNUM_W      = 3;
  localparam int CFG_INDEX_W = 3;
  localparam int AXIS_W      = 3;
  localparam int SLOT_W      = 3;
  localparam int DIGIT_W     = 8;

  localparam int WRENCH_W   = 27;
  localparam int FORCE_W    = WRENCH_W + 11;
  localparam int RATIO_W    = FORCE_W + 15;
  localparam int CMD_SHIFT  = 15;
  localparam int DIV_STEPS  = 15;
  localparam int STEP_W     = 4;
  localparam int ONE_Q15    = 32768;
  localparam int DUTY_MAX   = 32767;
  localparam int DUTY_MIN   = -32768;

  localparam logic [SLOT_W-1:0] SLOT_FWD = 3'd6;
  localparam logic [SLOT_W-1:0] SLOT_REV = 3'd7;

  typedef enum logic {
    OP_MOTION = 1'b0,
    OP_LOAD   = 1'b1
  } op_t;

  typedef struct packed {
    logic               en;
    logic [INDEX_W-1:0] index;
    logic [WORD_W-1:0]  word;
  } tam_load_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_WRENCH,
    T_LANES,
    T_MERGE
  } top_state_t;

  typedef enum logic [2:0] {
    L_IDLE,
    L_FETCH,
    L_MUL,
    L_ACC,
    L_RFETCH,
    L_RMUL,
    L_RES
  } lane_state_t;

  typedef enum logic [2:0] {
    M_IDLE,
    M_SCAN,
    M_PREP,
    M_DIV,
    M_OUT
  } merge_state_t;

endpackage

[sv/tam_if.sv]
// command and duty channel interfaces
interface tam_in_if import tam_pkg::*; ();
  logic                     valid;
  logic                     ready;
  op_t                      operation;
  logic signed [CMD_W-1:0]  surge_command;
  logic signed [CMD_W-1:0]  sway_command;
  logic signed [CMD_W-1:0]  heave_command;
  logic signed [CMD_W-1:0]  roll_command;
  logic signed [CMD_W-1:0]  pitch_command;
  logic signed [CMD_W-1:0]  yaw_command;
  logic                     heave_invert;
  logic                     yaw_invert;
  logic [INDEX_W-1:0]       table_index;
  logic signed [WORD_W-1:0] table_word;

  modport source (
    output valid, operation, surge_command, sway_command, heave_command,
           roll_command, pitch_command, yaw_command, heave_invert, yaw_invert,
           table_index, table_word,
    input  ready
  );
  modport sink (
    input  valid, operation, surge_command, sway_command, heave_command,
           roll_command, pitch_command, yaw_command, heave_invert, yaw_invert,
           table_index, table_word,
    output ready
  );
endinterface

interface tam_out_if import tam_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [TNUM_W-1:0]        thruster_number;
  logic signed [DUTY_W-1:0] duty_value;
  logic                     last_thruster;

  modport source (
    output valid, thruster_number, duty_value, last_thruster,
    input  ready
  );
  modport sink (
    input  valid, thruster_number, duty_value, last_thruster,
    output ready
  );
endinterface

[sv/tam_lane.sv]
// one thruster lane: coefficient store, digit-serial multiply-accumulate and ratio
module tam_lane import tam_pkg::*; #(
  parameter int THRUSTER_COUNT    = THRUSTER_COUNT_DEF,
  parameter int COEFFICIENT_WIDTH = COEF_WIDTH_DEF,
  parameter int LANE              = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  tam_load_t                  load,
  input  logic                       start,
  input  logic signed [WRENCH_W-1:0] wrench [AXIS_COUNT],
  output logic                       done,
  output logic                       dead,
  output logic signed [RATIO_W-1:0]  ratio,
  output logic signed [RATIO_W:0]    sratio
);

  localparam int ND      = (COEFFICIENT_WIDTH + DIGIT_W - 1) / DIGIT_W;
  localparam int EXT_W   = ND * DIGIT_W;
  localparam int ACC_W   = FORCE_W + EXT_W;
  localparam int DG_W    = (ND > 1) ? $clog2(ND) : 1;
  localparam int FRAC    = COEFFICIENT_WIDTH - 8;
  localparam int RSH     = COEFFICIENT_WIDTH - 15;
  localparam int WIDE_W  = WORD_W + 48;
  localparam int MAT_LO  = LANE * AXIS_COUNT;
  localparam int FWD_IDX = THRUSTER_COUNT * AXIS_COUNT + LANE;
  localparam int REV_IDX = THRUSTER_COUNT * (AXIS_COUNT + 1) + LANE;

  lane_state_t state, state_next;

  logic [COEFFICIENT_WIDTH-1:0] mem [2**SLOT_W];
  logic [COEFFICIENT_WIDTH-1:0] rdata;
  logic [SLOT_W-1:0]            rd_addr;
  logic                         wr_en;
  logic [SLOT_W-1:0]            wr_slot;
  logic [7:0]                   idx8;
  logic signed [WIDE_W-1:0]     wide_word;

  logic [AXIS_W-1:0]            axis;
  logic [DG_W-1:0]              dig;
  logic signed [FORCE_W-1:0]    force_acc;
  logic signed [ACC_W-1:0]      acc;
  logic signed [ACC_W-1:0]      acc_next;
  logic signed [ACC_W-1:0]      acc_sh;
  logic signed [ACC_W-1:0]      acc_r;
  logic signed [FORCE_W-1:0]    mcand;
  logic signed [EXT_W-1:0]      coef_ext;
  logic [DIGIT_W-1:0]           digit;
  logic signed [DIGIT_W:0]      dsig;
  logic signed [FORCE_W+DIGIT_W:0] term;
  logic signed [RATIO_W-1:0]    rv;
  logic signed [RATIO_W:0]      rv_ext;
  logic                         fwd;
  logic                         top_digit;

  // load decode
  assign idx8      = {2'b00, load.index};
  assign wide_word = WIDE_W'($signed(load.word));

  always_comb begin
    wr_en   = 1'b0;
    wr_slot = '0;
    if (load.en) begin
      if (idx8 >= 8'(MAT_LO) && idx8 < 8'(MAT_LO + AXIS_COUNT)) begin
        wr_en   = 1'b1;
        wr_slot = SLOT_W'(idx8 - 8'(MAT_LO));
      end else if (idx8 == 8'(FWD_IDX)) begin
        wr_en   = 1'b1;
        wr_slot = SLOT_FWD;
      end else if (idx8 == 8'(REV_IDX)) begin
        wr_en   = 1'b1;
        wr_slot = SLOT_REV;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_slot] <= wide_word[COEFFICIENT_WIDTH-1:0];
    end
    rdata <= mem[rd_addr];
  end

  // digit-serial multiplier, most significant digit first
  assign fwd       = force_acc > 0;
  assign coef_ext  = EXT_W'($signed(rdata));
  assign digit     = coef_ext[dig*DIGIT_W +: DIGIT_W];
  assign top_digit = (dig == DG_W'(ND - 1));
  assign dsig      = top_digit ? $signed({digit[DIGIT_W-1], digit}) : $signed({1'b0, digit});
  assign mcand     = (state == L_RMUL) ? force_acc : FORCE_W'(wrench[axis]);
  assign term      = mcand * dsig;
  assign acc_next  = (top_digit ? ACC_W'(0) : (acc <<< DIGIT_W)) + ACC_W'(term);
  assign acc_sh    = acc >>> FRAC;
  assign acc_r     = acc >>> RSH;
  assign rv        = $signed(acc_r[RATIO_W-1:0]);
  assign rv_ext    = (RATIO_W+1)'(rv);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_addr    = SLOT_W'(axis);
    case (state)
      L_IDLE: begin
        if (start) begin
          state_next = L_FETCH;
        end
      end
      L_FETCH: state_next = L_MUL;
      L_MUL: begin
        if (dig == '0) begin
          state_next = L_ACC;
        end
      end
      L_ACC: begin
        state_next = (axis == AXIS_W'(AXIS_COUNT - 1)) ? L_RFETCH : L_FETCH;
      end
      L_RFETCH: begin
        rd_addr    = fwd ? SLOT_FWD : SLOT_REV;
        state_next = L_RMUL;
      end
      L_RMUL: begin
        rd_addr = fwd ? SLOT_FWD : SLOT_REV;
        if (dig == '0) begin
          state_next = L_RES;
        end
      end
      L_RES: begin
        rd_addr    = fwd ? SLOT_FWD : SLOT_REV;
        state_next = L_IDLE;
      end
      default: state_next = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == L_RES);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      L_IDLE: begin
        if (start) begin
          axis      <= '0;
          force_acc <= '0;
        end
      end
      L_FETCH, L_RFETCH: dig <= DG_W'(ND - 1);
      L_MUL, L_RMUL: begin
        acc <= acc_next;
        dig <= dig - 1'b1;
      end
      L_ACC: begin
        force_acc <= force_acc + $signed(acc_sh[FORCE_W-1:0]);
        axis      <= axis + 1'b1;
      end
      L_RES: begin
        dead <= (rdata == '0);
        if (rdata == '0) begin
          ratio  <= RATIO_W'(ONE_Q15);
          sratio <= '0;
        end else begin
          ratio  <= rv;
          sratio <= fwd ? rv_ext : -rv_ext;
        end
      end
      default: ;
    endcase
  end

endmodule

[sv/tam_merge.sv]
// merge stage: common factor over lanes, restoring division and duty output
module tam_merge import tam_pkg::*; #(
  parameter int THRUSTER_COUNT = THRUSTER_COUNT_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [RATIO_W-1:0] ratio  [THRUSTER_COUNT],
  input  logic signed [RATIO_W:0]   sratio [THRUSTER_COUNT],
  input  logic                      dead   [THRUSTER_COUNT],
  output logic                      done,
  tam_out_if.source                 out_ch
);

  localparam int TIW = (THRUSTER_COUNT > 1) ? $clog2(THRUSTER_COUNT) : 1;

  merge_state_t state, state_next;

  logic [TIW-1:0]            idx;
  logic signed [RATIO_W-1:0] factor;
  logic [RATIO_W:0]          rem;
  logic [RATIO_W:0]          rem2;
  logic [RATIO_W:0]          mag;
  logic [RATIO_W:0]          f_ext;
  logic [DIV_STEPS-1:0]      q;
  logic [DIV_STEPS-1:0]      qn;
  logic [STEP_W-1:0]         step;
  logic                      neg;
  logic                      qbit;
  logic                      last_idx;
  logic signed [DUTY_W-1:0]  duty;

  assign last_idx = (idx == TIW'(THRUSTER_COUNT - 1));
  assign mag      = sratio[idx][RATIO_W] ? unsigned'(-sratio[idx]) : unsigned'(sratio[idx]);
  assign f_ext    = (RATIO_W+1)'(unsigned'(factor));
  assign rem2     = {rem[RATIO_W-1:0], 1'b0};
  assign qbit     = (rem2 >= f_ext);
  assign qn       = {q[DIV_STEPS-2:0], qbit};

  assign out_ch.valid           = (state == M_OUT);
  assign out_ch.thruster_number = TNUM_W'(idx);
  assign out_ch.duty_value      = duty;
  assign out_ch.last_thruster   = last_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    case (state)
      M_IDLE: begin
        if (start) begin
          state_next = M_SCAN;
        end
      end
      M_SCAN: begin
        if (last_idx) begin
          state_next = M_PREP;
        end
      end
      M_PREP: begin
        if (dead[idx] || mag >= f_ext) begin
          state_next = M_OUT;
        end else begin
          state_next = M_DIV;
        end
      end
      M_DIV: begin
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          state_next = M_OUT;
        end
      end
      M_OUT: begin
        if (out_ch.ready) begin
          if (last_idx) begin
            state_next = M_IDLE;
            done       = 1'b1;
          end else begin
            state_next = M_PREP;
          end
        end
      end
      default: state_next = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      M_IDLE: begin
        if (start) begin
          idx    <= '0;
          factor <= RATIO_W'(ONE_Q15);
        end
      end
      M_SCAN: begin
        if (ratio[idx] > factor) begin
          factor <= ratio[idx];
        end
        idx <= last_idx ? '0 : idx + 1'b1;
      end
      M_PREP: begin
        rem  <= mag;
        q    <= '0;
        step <= '0;
        neg  <= sratio[idx][RATIO_W];
        if (dead[idx]) begin
          duty <= '0;
        end else if (mag >= f_ext) begin
          duty <= sratio[idx][RATIO_W] ? DUTY_W'(DUTY_MIN) : DUTY_W'(DUTY_MAX);
        end
      end
      M_DIV: begin
        rem  <= qbit ? rem2 - f_ext : rem2;
        q    <= qn;
        step <= step + 1'b1;
        if (step == STEP_W'(DIV_STEPS - 1)) begin
          duty <= neg ? -$signed({1'b0, qn}) : $signed({1'b0, qn});
        end
      end
      M_OUT: begin
        if (out_ch.ready && !last_idx) begin
          idx <= idx + 1'b1;
        end
      end
      default: ;
    endcase
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == M_IDLE)
    else $error("merge started while busy");

  a_div_below: assert property (@(posedge clk) disable iff (rst)
    state == M_DIV |-> rem < f_ext)
    else $error("division remainder not below factor");

  a_factor_floor: assert property (@(posedge clk) disable iff (rst)
    state == M_PREP |-> factor >= RATIO_W'(ONE_Q15))
    else $error("common factor below one");

endmodule

[sv/thruster_allocation_mixer.sv]
// top level: command capture, wrench scaling, thruster lanes and merge stage
// the lane multipliers are digit-serial and the merge-stage duty divider resolves one
// quotient bit per cycle
// a table load transaction gives no result; one command in flight
// synchronous active-high reset clears control state; the coefficient store is
// undefined until written and the force limits reset to zero
module thruster_allocation_mixer import tam_pkg::*; #(
  parameter int THRUSTER_COUNT    = THRUSTER_COUNT_DEF,
  parameter int COEFFICIENT_WIDTH = COEF_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [LIMIT_W-1:0]     cfg_data,
  tam_in_if.sink                 in_ch,
  tam_out_if.source              out_ch
);

  top_state_t state, state_next;

  logic [LIMIT_W-1:0]         limit  [AXIS_COUNT];
  logic signed [CMD_W:0]      cmd    [AXIS_COUNT];
  logic signed [WRENCH_W-1:0] wrench [AXIS_COUNT];
  logic [AXIS_W-1:0]          j;
  logic signed [CMD_W+LIMIT_W+1:0] wprod;
  logic signed [CMD_W+LIMIT_W+1:0] wsh;

  logic                       accept;
  logic                       lane_start;
  logic                       merge_start;
  logic                       merge_done;
  tam_load_t                  load;

  logic [THRUSTER_COUNT-1:0]  lane_done;
  logic                       lane_dead  [THRUSTER_COUNT];
  logic signed [RATIO_W-1:0]  lane_ratio [THRUSTER_COUNT];
  logic signed [RATIO_W:0]    lane_sratio[THRUSTER_COUNT];

  assign in_ch.ready = (state == T_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign load.en     = accept && (in_ch.operation == OP_LOAD);
  assign load.index  = in_ch.table_index;
  assign load.word   = in_ch.table_word;

  assign wprod = cmd[j] * $signed({1'b0, limit[j]});
  assign wsh   = wprod >>> CMD_SHIFT;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < AXIS_COUNT; a++) begin
        limit[a] <= '0;
      end
    end else if (cfg_we && cfg_index < CFG_INDEX_W'(AXIS_COUNT)) begin
      limit[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    lane_start  = 1'b0;
    merge_start = 1'b0;
    case (state)
      T_IDLE: begin
        if (accept && in_ch.operation == OP_MOTION) begin
          state_next = T_WRENCH;
        end
      end
      T_WRENCH: begin
        if (j == AXIS_W'(AXIS_COUNT - 1)) begin
          lane_start = 1'b1;
          state_next = T_LANES;
        end
      end
      T_LANES: begin
        if (lane_done[0]) begin
          merge_start = 1'b1;
          state_next  = T_MERGE;
        end
      end
      T_MERGE: begin
        if (merge_done) begin
          state_next = T_IDLE;
        end
      end
      default: state_next = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      T_IDLE: begin
        if (accept && in_ch.operation == OP_MOTION) begin
          j      <= '0;
          cmd[0] <= (CMD_W+1)'(in_ch.surge_command);
          cmd[1] <= (CMD_W+1)'(in_ch.sway_command);
          cmd[2] <= in_ch.heave_invert ? -(CMD_W+1)'(in_ch.heave_command)
                                       : (CMD_W+1)'(in_ch.heave_command);
          cmd[3] <= (CMD_W+1)'(in_ch.roll_command);
          cmd[4] <= (CMD_W+1)'(in_ch.pitch_command);
          cmd[5] <= in_ch.yaw_invert ? -(CMD_W+1)'(in_ch.yaw_command)
                                     : (CMD_W+1)'(in_ch.yaw_command);
        end
      end
      T_WRENCH: begin
        wrench[j] <= wsh[WRENCH_W-1:0];
        j         <= j + 1'b1;
      end
      default: ;
    endcase
  end

  for (genvar t = 0; t < THRUSTER_COUNT; t++) begin : g_lane
    tam_lane #(
      .THRUSTER_COUNT   (THRUSTER_COUNT),
      .COEFFICIENT_WIDTH(COEFFICIENT_WIDTH),
      .LANE             (t)
    ) u_lane (
      .clk   (clk),
      .rst   (rst),
      .load  (load),
      .start (lane_start),
      .wrench(wrench),
      .done  (lane_done[t]),
      .dead  (lane_dead[t]),
      .ratio (lane_ratio[t]),
      .sratio(lane_sratio[t])
    );
  end

  tam_merge #(
    .THRUSTER_COUNT(THRUSTER_COUNT)
  ) u_merge (
    .clk   (clk),
    .rst   (rst),
    .start (merge_start),
    .ratio (lane_ratio),
    .sratio(lane_sratio),
    .dead  (lane_dead),
    .done  (merge_done),
    .out_ch(out_ch)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    accept |-> !out_ch.valid)
    else $error("transaction accepted while results pending");

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    (|lane_done) |-> (&lane_done))
    else $error("lanes out of step");

  a_merge_done_state: assert property (@(posedge clk) disable iff (rst)
    merge_done |-> state == T_MERGE)
    else $error("merge finished outside merge phase");

  a_lane_start: assert property (@(posedge clk) disable iff (rst)
    lane_start |=> state == T_LANES && lane_done == '0)
    else $error("lane start sequencing");

endmodule

[test/thruster_allocation_mixer_tb.sv]
// self-checking testbench for the thruster allocation mixer with a duty predictor
`timescale 1ns / 100ps

module thruster_allocation_mixer_tb;
  import tam_pkg::*;

  localparam int THRUSTERS = THRUSTER_COUNT_DEF;
  localparam int COEF_FRAC = COEF_WIDTH_DEF - 8;
  localparam int FWD_BASE = THRUSTERS * AXIS_COUNT;
  localparam int REV_BASE = THRUSTERS * (AXIS_COUNT + 1);
  localparam int TABLE_DEPTH = THRUSTERS * 8;
  localparam int SETTLE_CYCLES = 300;

  typedef enum int {
    REG_SURGE, REG_SWAY, REG_HEAVE, REG_ROLL, REG_PITCH, REG_YAW, REG_COUNT
  } limit_reg_t;

  typedef struct {
    op_t                      op;
    logic signed [CMD_W-1:0]  axis_cmd [AXIS_COUNT];
    logic                     heave_inv;
    logic                     yaw_inv;
    logic [INDEX_W-1:0]       index;
    logic signed [WORD_W-1:0] word;
  } command_t;

  typedef struct {
    logic [TNUM_W-1:0]        tnum;
    logic signed [DUTY_W-1:0] duty;
    logic                     last;
  } duty_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [LIMIT_W-1:0] cfg_data = '0;

  tam_in_if in_ch ();
  tam_out_if out_ch ();

  thruster_allocation_mixer uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  command_t pending_cmds[$];
  duty_t expected_duties[$];
  logic [LIMIT_W-1:0] axis_limit [AXIS_COUNT];
  logic signed [WORD_W-1:0] coef_table [TABLE_DEPTH];
  bit failed = 0;
  bit no_idle = 0;
  bit in_fire = 0;
  int in_gap = 0;
  int out_stall = 0;

  initial forever #5 clk = ~clk;

  initial begin
    #10ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void predict_duties(input command_t c);
    longint wrench [AXIS_COUNT];
    longint signed_ratio [THRUSTERS];
    bit dead [THRUSTERS];
    longint factor, cmdv, thrust, recip, ratio;
    logic signed [127:0] a, b, p;
    logic [127:0] mag, f;
    duty_t d;
    bit fwd;
    factor = ONE_Q15;
    for (int j = 0; j < AXIS_COUNT; j++) begin
      cmdv = c.axis_cmd[j];
      if ((j == REG_HEAVE && c.heave_inv) || (j == REG_YAW && c.yaw_inv)) cmdv = -cmdv;
      wrench[j] = (cmdv * longint'(axis_limit[j])) >>> CMD_SHIFT;
    end
    for (int i = 0; i < THRUSTERS; i++) begin
      thrust = 0;
      for (int j = 0; j < AXIS_COUNT; j++) begin
        a = wrench[j];
        b = coef_table[i * AXIS_COUNT + j];
        p = (a * b) >>> COEF_FRAC;
        thrust += longint'(p);
      end
      fwd = thrust > 0;
      recip = fwd ? coef_table[FWD_BASE + i] : coef_table[REV_BASE + i];
      dead[i] = recip == 0;
      if (dead[i]) begin
        ratio = ONE_Q15;
        signed_ratio[i] = 0;
      end else begin
        a = thrust;
        b = recip;
        p = (a * b) >>> (COEF_FRAC - 7);
        ratio = longint'(p);
        signed_ratio[i] = fwd ? ratio : -ratio;
      end
      if (ratio > factor) factor = ratio;
    end
    for (int i = 0; i < THRUSTERS; i++) begin
      a = signed_ratio[i];
      mag = a < 0 ? -a : a;
      f = factor;
      d.tnum = TNUM_W'(i);
      d.last = (i == THRUSTERS - 1);
      if (dead[i]) d.duty = '0;
      else if (mag >= f) d.duty = a < 0 ? DUTY_W'(DUTY_MIN) : DUTY_W'(DUTY_MAX);
      else begin
        mag = (mag << DIV_STEPS) / f;
        d.duty = a < 0 ? -mag[15:0] : mag[15:0];
      end
      expected_duties.push_back(d);
    end
  endfunction

  // monitor: checks duty transactions and updates the predictor state
  always @(posedge clk) begin
    duty_t e;
    in_fire <= in_ch.valid && in_ch.ready;
    if (cfg_we && cfg_index < REG_COUNT) axis_limit[cfg_index] = cfg_data;
    if (out_ch.valid && out_ch.ready) begin
      if (expected_duties.size() == 0) begin
        failed = 1;
        $display("%0t: unexpected duty thruster=%0d duty=%0d last=%0b", $time,
                 out_ch.thruster_number, out_ch.duty_value, out_ch.last_thruster);
      end else begin
        e = expected_duties.pop_front();
        if (e.tnum !== out_ch.thruster_number || e.duty !== out_ch.duty_value ||
            e.last !== out_ch.last_thruster) begin
          failed = 1;
          $display("%0t: mismatch expected thruster=%0d duty=%0d last=%0b, actual %0d %0d %0b",
                   $time, e.tnum, e.duty, e.last, out_ch.thruster_number,
                   out_ch.duty_value, out_ch.last_thruster);
        end
      end
    end
    if (in_ch.valid && in_ch.ready) begin
      if (in_ch.operation == OP_LOAD) coef_table[in_ch.table_index] = in_ch.table_word;
      else begin
        command_t c;
        c.op = OP_MOTION;
        c.axis_cmd[0] = in_ch.surge_command;
        c.axis_cmd[1] = in_ch.sway_command;
        c.axis_cmd[2] = in_ch.heave_command;
        c.axis_cmd[3] = in_ch.roll_command;
        c.axis_cmd[4] = in_ch.pitch_command;
        c.axis_cmd[5] = in_ch.yaw_command;
        c.heave_inv = in_ch.heave_invert;
        c.yaw_inv = in_ch.yaw_invert;
        predict_duties(c);
      end
    end
  end

  // driver: feeds command transactions with random idle bursts and random output ready stalls
  always @(negedge clk) begin
    command_t c;
    if (rst) begin
      in_ch.valid <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      if (out_stall > 0) out_stall--;
      else if (!no_idle && $urandom_range(0, 9) == 0) out_stall = $urandom_range(1, 6);
      out_ch.ready <= (out_stall == 0);
      if (!in_ch.valid || in_fire) begin
        if (in_gap > 0) in_gap--;
        else if (!no_idle && $urandom_range(0, 7) == 0) in_gap = $urandom_range(1, 6);
        if (in_gap == 0 && pending_cmds.size() > 0) begin
          c = pending_cmds.pop_front();
          in_ch.operation <= c.op;
          in_ch.surge_command <= c.axis_cmd[0];
          in_ch.sway_command <= c.axis_cmd[1];
          in_ch.heave_command <= c.axis_cmd[2];
          in_ch.roll_command <= c.axis_cmd[3];
          in_ch.pitch_command <= c.axis_cmd[4];
          in_ch.yaw_command <= c.axis_cmd[5];
          in_ch.heave_invert <= c.heave_inv;
          in_ch.yaw_invert <= c.yaw_inv;
          in_ch.table_index <= c.index;
          in_ch.table_word <= c.word;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  function automatic logic signed [CMD_W-1:0] pick_cmd();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      default: return CMD_W'($urandom);
    endcase
  endfunction

  function automatic command_t load_word(input int idx, input logic signed [WORD_W-1:0] w);
    command_t c;
    c.op = OP_LOAD;
    foreach (c.axis_cmd[j]) c.axis_cmd[j] = CMD_W'($urandom);
    c.heave_inv = 1'($urandom);
    c.yaw_inv = 1'($urandom);
    c.index = INDEX_W'(idx);
    c.word = w;
    return c;
  endfunction

  function automatic command_t motion(input logic signed [CMD_W-1:0] v, input bit hi,
                                      input bit yi);
    command_t c;
    c.op = OP_MOTION;
    foreach (c.axis_cmd[j]) c.axis_cmd[j] = v;
    c.heave_inv = hi;
    c.yaw_inv = yi;
    c.index = INDEX_W'($urandom);
    c.word = WORD_W'($urandom);
    return c;
  endfunction

  function automatic logic signed [WORD_W-1:0] table_value(input int idx);
    int kind;
    kind = $urandom_range(0, 9);
    if (kind == 0) return '0;
    if (kind == 1) return WORD_W'($urandom);
    if (idx < FWD_BASE) return $signed($urandom_range(0, 1 << 25)) - (1 << 24);
    if (idx < REV_BASE) return $urandom_range(1, 1 << 22);
    return -$signed($urandom_range(1, 1 << 22));
  endfunction

  function automatic command_t random_item();
    command_t c;
    if ($urandom_range(0, 6) == 0) begin
      c = load_word($urandom_range(0, TABLE_DEPTH - 1), '0);
      c.word = table_value(c.index);
    end else begin
      c = motion('0, 1'($urandom), 1'($urandom));
      foreach (c.axis_cmd[j]) c.axis_cmd[j] = pick_cmd();
    end
    return c;
  endfunction

  task automatic write_limits(input bit extreme_high, input bit pick_random);
    for (int k = 0; k < (1 << CFG_INDEX_W); k++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= CFG_INDEX_W'(k);
      cfg_data <= pick_random ? LIMIT_W'($urandom_range(0, 24'hFFFFFF))
                              : (extreme_high ? 24'hFFFFFF : '0);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    wait (pending_cmds.size() == 0 && !in_ch.valid && expected_duties.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = OP_MOTION;
    in_ch.surge_command = '0;
    in_ch.sway_command = '0;
    in_ch.heave_command = '0;
    in_ch.roll_command = '0;
    in_ch.pitch_command = '0;
    in_ch.yaw_command = '0;
    in_ch.heave_invert = 1'b0;
    in_ch.yaw_invert = 1'b0;
    in_ch.table_index = '0;
    in_ch.table_word = '0;
    out_ch.ready = 1'b0;
    foreach (axis_limit[j]) axis_limit[j] = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // full table before the first motion command, with zero or full-range random words at random spots
    for (int i = 0; i < TABLE_DEPTH; i++) pending_cmds.push_back(load_word(i, table_value(i)));
    pending_cmds.push_back(motion(16'sh7FFF, 0, 0));
    drain();

    write_limits(1, 0);
    pending_cmds.push_back(load_word(0, 32'sh7FFFFFFF));
    pending_cmds.push_back(load_word(1, 32'sh80000000));
    pending_cmds.push_back(load_word(FWD_BASE, '0));
    pending_cmds.push_back(load_word(REV_BASE + 1, '0));
    pending_cmds.push_back(load_word(REV_BASE + 2, 32'sh7FFFFFFF));
    pending_cmds.push_back(motion(16'sh7FFF, 0, 0));
    pending_cmds.push_back(motion(16'sh8000, 0, 0));
    pending_cmds.push_back(motion(16'sh7FFF, 1, 0));
    pending_cmds.push_back(motion(16'sh8000, 0, 1));
    pending_cmds.push_back(motion(16'sh8000, 1, 1));
    pending_cmds.push_back(motion('0, 0, 0));
    pending_cmds.push_back(motion(16'sh0001, 1, 1));
    pending_cmds.push_back(motion(-16'sh0001, 0, 1));
    for (int n = 0; n < 90; n++) pending_cmds.push_back(random_item());
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      write_limits(0, 1);
      if (ph == 2) no_idle = 1;
      for (int n = 0; n < 90; n++) pending_cmds.push_back(random_item());
      drain();
    end

    write_limits(0, 0);
    for (int n = 0; n < 10; n++) pending_cmds.push_back(random_item());
    drain();

    if (!failed) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

[files.f]
sv/tam_pkg.sv
sv/tam_if.sv
sv/tam_lane.sv
sv/tam_merge.sv
sv/thruster_allocation_mixer.sv
test/thruster_allocation_mixer_tb.sv
